// ===== sv/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, register codes and constants for the complementary tilt filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int GAIN_FRAC           = 24;
    localparam int CW                  = 27;   // CORDIC x/y width
    localparam int ZW                  = 32;   // CORDIC angle accumulator width
    localparam int RW                  = 24;   // root width
    localparam int NW                  = 48;   // radicand width

    // register indexes
    localparam logic [2:0] REG_OFFSET_GX    = 3'd0;
    localparam logic [2:0] REG_OFFSET_GY    = 3'd1;
    localparam logic [2:0] REG_OFFSET_GZ    = 3'd2;
    localparam logic [2:0] REG_STEP_GAIN_XY = 3'd3;
    localparam logic [2:0] REG_STEP_GAIN_Z  = 3'd4;
    localparam logic [2:0] REG_BLEND_WEIGHT = 3'd5;

    localparam logic [15:0] GAIN_XY_RST = 16'd4197;
    localparam logic [15:0] GAIN_Z_RST  = 16'd3885;
    localparam logic [16:0] BLEND_RST   = 17'd52429;
    localparam logic [16:0] BLEND_ONE   = 17'd65536;

    typedef struct packed {
        logic                 valid;
        logic                 tag;     // 0: tilt x, 1: tilt y
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_word_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                0:  v = 32'sd754974720;
                1:  v = 32'sd445687602;
                2:  v = 32'sd235489089;
                3:  v = 32'sd119537938;
                4:  v = 32'sd60000934;
                5:  v = 32'sd30029717;
                6:  v = 32'sd15018523;
                7:  v = 32'sd7509720;
                8:  v = 32'sd3754917;
                9:  v = 32'sd1877466;
                10: v = 32'sd938734;
                11: v = 32'sd469367;
                12: v = 32'sd234684;
                13: v = 32'sd117342;
                14: v = 32'sd58671;
                15: v = 32'sd29335;
                16: v = 32'sd14668;
                17: v = 32'sd7334;
                18: v = 32'sd3667;
                19: v = 32'sd1833;
                20: v = 32'sd917;
                21: v = 32'sd458;
                22: v = 32'sd229;
                23: v = 32'sd115;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        begin
            if (v > 52'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -52'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== sv/ctf_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ctf_cordic_cell
// One vectoring micro-rotation of the CORDIC chain, registered.
// ----------------------------------------------------------------------------
module ctf_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctf_pkg::cordic_word_t word_in,
    output ctf_pkg::cordic_word_t word_out
);

    ctf_pkg::cordic_word_t word_reg, word_next;
    logic signed [ctf_pkg::CW-1:0] xs, ys;

    always_comb begin
        xs        = word_in.x >>> STEP;
        ys        = word_in.y >>> STEP;
        word_next = word_in;
        if (!word_in.y[ctf_pkg::CW-1]) begin
            word_next.x = word_in.x + ys;
            word_next.y = word_in.y - xs;
            word_next.z = word_in.z + ctf_pkg::atan_q24(STEP);
        end else begin
            word_next.x = word_in.x - ys;
            word_next.y = word_in.y + xs;
            word_next.z = word_in.z - ctf_pkg::atan_q24(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== sv/ctf_sqrt.sv =====
// ----------------------------------------------------------------------------
// ctf_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ctf_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [ctf_pkg::NW-1:0]   radicand,
    output logic                     done,
    output logic [ctf_pkg::RW-1:0]   root
);

    logic [ctf_pkg::NW-1:0] rem_reg, rem_next;
    logic [ctf_pkg::NW-1:0] res_reg, res_next;
    logic [ctf_pkg::NW-1:0] bit_reg, bit_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ctf_pkg::NW-1:0] trial;

    always_comb begin
        trial     = res_reg + bit_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = ctf_pkg::NW'(1) << (ctf_pkg::NW - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ctf_pkg::RW-1:0];

endmodule

// ===== sv/complementary_tilt_filter_top.sv =====
// ----------------------------------------------------------------------------
// complementary_tilt_filter_top
// Gyro/accelerometer attitude estimator: integrates offset-corrected rates and
// blends x/y with accelerometer tilt from a CORDIC atan2 chain.
// ----------------------------------------------------------------------------
// An accepted input word passes the states ST_MUL, ST_INT, ST_SQX, ST_SQY,
//   ST_CORD, ST_BLEND and ST_SUM before m_tvalid goes high.
// Input words are taken only in ST_IDLE, one at a time; the two serial square
//   roots (one shared unit) and the CORDIC chain depth set the throughput.
// A new input word is taken while a finished result still waits on m_tready;
//   the next result then holds the sequencer until the output register frees.
// Reset (aresetn low, synchronous): angle state cleared to zero, registers to
//   their defaults, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module complementary_tilt_filter_top #(
    parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // rate_x[15:0], rate_y[31:16], rate_z[47:32], acc_x[63:48], acc_y[79:64],
    // acc_z[95:80]
    input  logic [95:0] s_tdata,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // angle_x[31:0], angle_y[63:32], angle_z[95:64]
    output logic [95:0] m_tdata
);

    localparam int SHIFT = ctf_pkg::GAIN_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [35:0] HALF36 = 36'sd1 <<< (SHIFT - 1);
    localparam logic signed [32:0] HALF33 = 33'sd1 <<< (SHIFT - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_INT   = 8'b0000_0100,
        ST_SQX   = 8'b0000_1000,
        ST_SQY   = 8'b0001_0000,
        ST_CORD  = 8'b0010_0000,
        ST_BLEND = 8'b0100_0000,
        ST_SUM   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic signed [15:0] offset_gx_reg, offset_gy_reg, offset_gz_reg;
    logic [15:0]        gain_xy_reg, gain_z_reg;
    logic [16:0]        blend_reg;

    // angle state
    logic signed [31:0] prev_x_reg, prev_y_reg, prev_z_reg;

    // captured input word
    logic signed [15:0] rx_reg, ry_reg, rz_reg, ax_reg, ay_reg, az_reg;

    // products and intermediate angles
    logic [30:0]        ax2_reg, ay2_reg, az2_reg;
    logic signed [33:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] int_x_reg, int_y_reg, int_z_reg;
    logic signed [31:0] tilt_x_reg, tilt_y_reg;
    logic               zero_x_reg, zero_y_reg;
    logic signed [49:0] bxi_reg, bxt_reg, byi_reg, byt_reg;

    // output register
    logic               m_valid_reg;
    logic [95:0]        m_data_reg;

    // sqrt unit
    logic                       sq_start, sq_done;
    logic [ctf_pkg::NW-1:0]     sq_n;
    logic [ctf_pkg::RW-1:0]     sq_root;

    // CORDIC chain
    ctf_pkg::cordic_word_t chain [0:CORDIC_STEPS];
    ctf_pkg::cordic_word_t chain_in;

    // combinational helpers
    logic signed [16:0] dx, dy, dz;
    logic signed [35:0] stx, sty, stz;
    logic [31:0]        sum_yz, sum_xz;
    logic signed [32:0] z_rnd;
    logic [16:0]        k_eff, k_inv;
    logic signed [50:0] sum_bx, sum_by;
    logic               out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        dx  = 17'(rx_reg) - 17'(offset_gx_reg);
        dy  = 17'(ry_reg) - 17'(offset_gy_reg);
        dz  = 17'(rz_reg) - 17'(offset_gz_reg);
        // rate steps rounded to angle units
        stx = ($signed({{2{px_reg[33]}}, px_reg}) + HALF36) >>> SHIFT;
        sty = ($signed({{2{py_reg[33]}}, py_reg}) + HALF36) >>> SHIFT;
        stz = ($signed({{2{pz_reg[33]}}, pz_reg}) + HALF36) >>> SHIFT;
        sum_yz = {1'b0, ay2_reg} + {1'b0, az2_reg};
        sum_xz = {1'b0, ax2_reg} + {1'b0, az2_reg};
        z_rnd  = ($signed({chain[CORDIC_STEPS].z[31], chain[CORDIC_STEPS].z}) + HALF33)
                 >>> SHIFT;
        k_eff  = (blend_reg > ctf_pkg::BLEND_ONE) ? ctf_pkg::BLEND_ONE : blend_reg;
        k_inv  = ctf_pkg::BLEND_ONE - k_eff;
        sum_bx = {bxi_reg[49], bxi_reg} + {bxt_reg[49], bxt_reg} + 51'sd32768;
        sum_by = {byi_reg[49], byi_reg} + {byt_reg[49], byt_reg} + 51'sd32768;
    end

    // sqrt launch: tilt x in ST_INT, tilt y when the first root lands
    always_comb begin
        sq_start = 1'b0;
        sq_n     = '0;
        if (state_reg == ST_INT) begin
            sq_start = 1'b1;
            sq_n     = {sum_yz, 16'd0};
        end else if (state_reg == ST_SQX && sq_done) begin
            sq_start = 1'b1;
            sq_n     = {sum_xz, 16'd0};
        end
    end

    // chain feed: root as X, numerator * 256 (sign extended) as Y
    always_comb begin
        chain_in       = '0;
        chain_in.valid = sq_done && (state_reg == ST_SQX || state_reg == ST_SQY);
        chain_in.tag   = state_reg == ST_SQY;
        chain_in.x     = ctf_pkg::CW'({1'b0, sq_root});
        chain_in.y     = (state_reg == ST_SQY)
                         ? {{(ctf_pkg::CW-24){ay_reg[15]}}, ay_reg, 8'd0}
                         : {{(ctf_pkg::CW-24){ax_reg[15]}}, ax_reg, 8'd0};
    end

    assign chain[0] = chain_in;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ctf_cordic_cell #(
            .STEP(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .word_in (chain[g]),
            .word_out(chain[g+1])
        );
    end

    ctf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .radicand(sq_n),
        .done    (sq_done),
        .root    (sq_root)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_INT;
            ST_INT:   state_next = ST_SQX;
            ST_SQX:   if (sq_done) state_next = ST_SQY;
            ST_SQY:   if (sq_done) state_next = ST_CORD;
            ST_CORD:  if (chain[CORDIC_STEPS].valid && chain[CORDIC_STEPS].tag) begin
                          state_next = ST_BLEND;
                      end
            ST_BLEND: state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            offset_gx_reg <= '0;
            offset_gy_reg <= '0;
            offset_gz_reg <= '0;
            gain_xy_reg   <= ctf_pkg::GAIN_XY_RST;
            gain_z_reg    <= ctf_pkg::GAIN_Z_RST;
            blend_reg     <= ctf_pkg::BLEND_RST;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    ctf_pkg::REG_OFFSET_GX:    offset_gx_reg <= cfg_wdata[15:0];
                    ctf_pkg::REG_OFFSET_GY:    offset_gy_reg <= cfg_wdata[15:0];
                    ctf_pkg::REG_OFFSET_GZ:    offset_gz_reg <= cfg_wdata[15:0];
                    ctf_pkg::REG_STEP_GAIN_XY: gain_xy_reg   <= cfg_wdata[15:0];
                    ctf_pkg::REG_STEP_GAIN_Z:  gain_z_reg    <= cfg_wdata[15:0];
                    ctf_pkg::REG_BLEND_WEIGHT: blend_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_SUM && out_free) begin
                prev_x_reg  <= ctf_pkg::sat32({sum_bx[50], sum_bx >>> 16});
                prev_y_reg  <= ctf_pkg::sat32({sum_by[50], sum_by >>> 16});
                prev_z_reg  <= int_z_reg;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // datapath, no reset needed
        if (state_reg == ST_IDLE && s_tvalid) begin
            rx_reg <= s_tdata[15:0];
            ry_reg <= s_tdata[31:16];
            rz_reg <= s_tdata[47:32];
            ax_reg <= s_tdata[63:48];
            ay_reg <= s_tdata[79:64];
            az_reg <= s_tdata[95:80];
        end
        if (state_reg == ST_MUL) begin
            ax2_reg <= 31'(ax_reg * ax_reg);
            ay2_reg <= 31'(ay_reg * ay_reg);
            az2_reg <= 31'(az_reg * az_reg);
            px_reg  <= 34'(dx * $signed({1'b0, gain_xy_reg}));
            py_reg  <= 34'(dy * $signed({1'b0, gain_xy_reg}));
            pz_reg  <= 34'(dz * $signed({1'b0, gain_z_reg}));
        end
        if (state_reg == ST_INT) begin
            // x integrates minus gyro y, y integrates gyro x, z minus gyro z
            int_x_reg  <= ctf_pkg::sat32({{20{prev_x_reg[31]}}, prev_x_reg}
                                         - {{16{sty[35]}}, sty});
            int_y_reg  <= ctf_pkg::sat32({{20{prev_y_reg[31]}}, prev_y_reg}
                                         + {{16{stx[35]}}, stx});
            int_z_reg  <= ctf_pkg::sat32({{20{prev_z_reg[31]}}, prev_z_reg}
                                         - {{16{stz[35]}}, stz});
            zero_x_reg <= (ax_reg == 16'sd0) && (sum_yz == 32'd0);
            zero_y_reg <= (ay_reg == 16'sd0) && (sum_xz == 32'd0);
        end
        // tilt x leaves the chain while the second root is still running
        if (chain[CORDIC_STEPS].valid) begin
            if (!chain[CORDIC_STEPS].tag) begin
                tilt_x_reg <= zero_x_reg ? 32'sd0 : z_rnd[31:0];
            end else begin
                tilt_y_reg <= zero_y_reg ? 32'sd0 : z_rnd[31:0];
            end
        end
        if (state_reg == ST_BLEND) begin
            bxi_reg <= $signed({1'b0, k_eff}) * int_x_reg;
            bxt_reg <= $signed({1'b0, k_inv}) * tilt_x_reg;
            byi_reg <= $signed({1'b0, k_eff}) * int_y_reg;
            byt_reg <= $signed({1'b0, k_inv}) * tilt_y_reg;
        end
        if (state_reg == ST_SUM && out_free) begin
            m_data_reg <= {int_z_reg,
                           ctf_pkg::sat32({sum_by[50], sum_by >>> 16}),
                           ctf_pkg::sat32({sum_bx[50], sum_bx >>> 16})};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complementary tilt filter: a local predictor of
// the rate integration, CORDIC tilt and blend is checked word by word against
// the result stream under random bursts, stalls and register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC   = 16;
    localparam int STEPS  = 16;
    localparam int LAT    = 2 * 24 + STEPS + 8;
    localparam longint LIMIT = 3000000;

    // indexes past the register file, writes must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [15:0] rx, ry, rz, ax, ay, az;
    } sample_t;

    typedef struct {
        logic signed [31:0] ang_x, ang_y, ang_z;
    } attitude_t;

    // pending words for the driver; a pause marker holds the sender until
    // every expected attitude has arrived
    typedef struct {
        sample_t s;
        bit      pause;
    } job_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    complementary_tilt_filter_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // predictor state and register shadow
    longint gofs_x, gofs_y, gofs_z, gain_xy, gain_z, weight_k;
    longint est_x, est_y, est_z;

    job_t      pending_jobs[$];
    attitude_t expected_att[$];
    int        fail_count = 0;
    int        words_sent = 0;
    int        words_seen = 0;
    longint    cycle = 0;
    bit        hold_rx = 1'b0;       // long receiver hold-off request
    bit        in_taken = 1'b0;      // input word accepted at the last rising edge

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_to_angle(longint v);
        return (v + (64'sd1 <<< (ctf_pkg::GAIN_FRAC - FRAC - 1)))
               >>> (ctf_pkg::GAIN_FRAC - FRAC);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
                          30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                          469367, 234684, 117342, 58671, 29335, 14668, 7334, 3667,
                          1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    // tilt in degrees: atan2(num, sqrt(b^2 + c^2)) by CORDIC vectoring
    function automatic longint tilt_deg(longint num, longint b, longint c);
        longint cx, cy, cz, xs, ys;
        cx = int_root(longint'(b * b + c * c) << 16);
        cy = num * 256;
        cz = 0;
        if (cx == 0 && cy == 0) return 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = shr_floor(cx, i);
            ys = shr_floor(cy, i);
            if (cy >= 0) begin
                cx = cx + ys; cy = cy - xs; cz = cz + atan_step(i);
            end else begin
                cx = cx - ys; cy = cy + xs; cz = cz - atan_step(i);
            end
        end
        return round_to_angle(cz);
    endfunction

    function automatic longint mix(longint integ, longint tilt);
        longint k;
        k = (weight_k > 65536) ? 65536 : weight_k;
        return clamp32((k * integ + (65536 - k) * tilt + 32768) >>> 16);
    endfunction

    function automatic attitude_t predict_attitude(sample_t s);
        attitude_t a;
        longint ix, iy, iz;
        ix = clamp32(est_x - round_to_angle((longint'(s.ry) - gofs_y) * gain_xy));
        iy = clamp32(est_y + round_to_angle((longint'(s.rx) - gofs_x) * gain_xy));
        iz = clamp32(est_z - round_to_angle((longint'(s.rz) - gofs_z) * gain_z));
        est_x = mix(ix, tilt_deg(s.ax, s.ay, s.az));
        est_y = mix(iy, tilt_deg(s.ay, s.ax, s.az));
        est_z = iz;
        a.ang_x = est_x[31:0];
        a.ang_y = est_y[31:0];
        a.ang_z = est_z[31:0];
        return a;
    endfunction

    // mirror of the register file; unknown indexes are dropped
    function automatic void shadow_write(logic [2:0] idx, logic [16:0] v);
        case (idx)
            ctf_pkg::REG_OFFSET_GX:    gofs_x = longint'($signed(v[15:0]));
            ctf_pkg::REG_OFFSET_GY:    gofs_y = longint'($signed(v[15:0]));
            ctf_pkg::REG_OFFSET_GZ:    gofs_z = longint'($signed(v[15:0]));
            ctf_pkg::REG_STEP_GAIN_XY: gain_xy = longint'(v[15:0]);
            ctf_pkg::REG_STEP_GAIN_Z:  gain_z = longint'(v[15:0]);
            ctf_pkg::REG_BLEND_WEIGHT: weight_k = longint'(v);
            default: ;
        endcase
    endfunction

    // config writes only happen while the filter is idle
    task automatic write_reg(logic [2:0] idx, logic [16:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_write(idx, v);
    endtask

    task automatic wait_drained();
        while (pending_jobs.size() != 0 || expected_att.size() != 0 || s_tvalid)
            @(negedge aclk);
        repeat (LAT + 10) @(negedge aclk);
    endtask

    function automatic sample_t rand_sample(int mode);
        sample_t s;
        s.rx = 16'($urandom); s.ry = 16'($urandom); s.rz = 16'($urandom);
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        if (mode == 1) begin
            // gentle motion near level, the usual operating region
            s.rx = 16'($signed($urandom_range(0, 800)) - 400);
            s.ry = 16'($signed($urandom_range(0, 800)) - 400);
            s.rz = 16'($signed($urandom_range(0, 800)) - 400);
            s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.az = 16'(16384 + $signed($urandom_range(0, 2000)) - 1000);
        end
        return s;
    endfunction

    task automatic queue_sample(sample_t s);
        job_t j;
        j.s = s;
        j.pause = 1'b0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_pause();
        job_t j;
        j.s = '{default: 0};
        j.pause = 1'b1;
        pending_jobs.push_back(j);
    endtask

    task automatic directed_samples();
        sample_t s;
        s = '{default: 0};
        queue_sample(s);                                  // zero accel vector
        s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        queue_sample(s);
        s = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
        queue_sample(s);
        s = '{0, 0, 0, 16'sh7fff, 0, 0};                  // straight up on x
        queue_sample(s);
        s = '{0, 0, 0, -16'sh8000, 0, 0};
        queue_sample(s);
        s = '{0, 0, 0, 0, 16'sh7fff, 0};
        queue_sample(s);
        s = '{0, 0, 0, 0, 0, -16'sh8000};
        queue_sample(s);
        s = '{0, 0, 0, 0, 0, 16384};
        queue_sample(s);
        s = '{16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh0001, -16'sh0001, 16'sh0001};
        queue_sample(s);
        for (int i = 0; i < 8; i++) queue_sample(rand_sample(0));
        queue_pause();
    endtask

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                // taken at the last rising edge
                expected_att.push_back(predict_attitude(pending_jobs[0].s));
                void'(pending_jobs.pop_front());
                words_sent++;
            end
            if (!s_tvalid || in_taken) begin
                if (pending_jobs.size() != 0 && pending_jobs[0].pause) begin
                    s_tvalid <= 1'b0;
                    if (expected_att.size() == 0 && !in_taken)
                        void'(pending_jobs.pop_front());
                end else if (pending_jobs.size() == 0 || gap_left > 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_jobs[0].s.az, pending_jobs[0].s.ay,
                                pending_jobs[0].s.ax, pending_jobs[0].s.rz,
                                pending_jobs[0].s.ry, pending_jobs[0].s.rx};
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    int stall_mode = 0;
    always @(negedge aclk) begin
        if ($urandom_range(0, 499) == 0) stall_mode = $urandom_range(0, 3);
        if (hold_rx)
            m_tready <= 1'b0;
        else case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 299) != 0);
        endcase
    end

    // checker: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin
        attitude_t e;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_att.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end else begin
                e = expected_att.pop_front();
                if (m_tdata[31:0] !== e.ang_x) begin
                    $error("angle_x exp %0d got %0d", e.ang_x, $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tdata[63:32] !== e.ang_y) begin
                    $error("angle_y exp %0d got %0d", e.ang_y, $signed(m_tdata[63:32]));
                    fail_count++;
                end
                if (m_tdata[95:64] !== e.ang_z) begin
                    $error("angle_z exp %0d got %0d", e.ang_z, $signed(m_tdata[95:64]));
                    fail_count++;
                end
            end
        end
        if (cycle > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // stimulus and phase control
    initial begin
        logic [16:0] set_k[4] = '{17'd0, 17'd65536, 17'd131071, 17'd52429};
        gofs_x = 0; gofs_y = 0; gofs_z = 0;
        gain_xy = 4197; gain_z = 3885; weight_k = 52429;
        est_x = 0; est_y = 0; est_z = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        directed_samples();
        wait_drained();

        // register phases: extremes, then random settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 4) begin
                write_reg(ctf_pkg::REG_OFFSET_GX, (ph % 2) ? 17'h08000 : 17'h07fff);
                write_reg(ctf_pkg::REG_OFFSET_GY, (ph % 2) ? 17'h07fff : 17'h08000);
                write_reg(ctf_pkg::REG_OFFSET_GZ, (ph == 2) ? 17'h0 : 17'h08000);
                write_reg(ctf_pkg::REG_STEP_GAIN_XY, (ph < 2) ? 17'h0ffff : 17'h0);
                write_reg(ctf_pkg::REG_STEP_GAIN_Z, (ph == 1) ? 17'h0 : 17'h0ffff);
                write_reg(ctf_pkg::REG_BLEND_WEIGHT, set_k[ph]);
            end else begin
                write_reg(ctf_pkg::REG_OFFSET_GX, 17'($urandom_range(0, 131071)));
                write_reg(ctf_pkg::REG_OFFSET_GY, 17'($urandom_range(0, 131071)));
                write_reg(ctf_pkg::REG_OFFSET_GZ, 17'($urandom_range(0, 1023)));
                write_reg(ctf_pkg::REG_STEP_GAIN_XY, 17'($urandom_range(0, 131071)));
                write_reg(ctf_pkg::REG_STEP_GAIN_Z, 17'($urandom_range(0, 131071)));
                write_reg(ctf_pkg::REG_BLEND_WEIGHT, 17'($urandom_range(0, 131071)));
            end
            write_reg(REG_SPARE_LO, 17'h1ffff);           // unmapped, ignored
            write_reg(REG_SPARE_HI, 17'h0);
            for (int i = 0; i < 130; i++)
                queue_sample(rand_sample(($urandom_range(0, 3) != 0) ? 1 : 0));
            if (ph == 3) begin
                // long hold-off on the result side while words keep coming
                hold_rx = 1'b1;
                repeat (2000) @(negedge aclk);
                hold_rx = 1'b0;
            end
            if (ph == 5) queue_pause();
            wait_drained();
        end

        // restore the reset gains and blend weight and finish with plain traffic
        write_reg(ctf_pkg::REG_STEP_GAIN_XY, 17'(ctf_pkg::GAIN_XY_RST));
        write_reg(ctf_pkg::REG_STEP_GAIN_Z, 17'(ctf_pkg::GAIN_Z_RST));
        write_reg(ctf_pkg::REG_BLEND_WEIGHT, ctf_pkg::BLEND_RST);
        for (int i = 0; i < 40; i++) queue_sample(rand_sample(1));
        wait_drained();

        $display("covered %0d input words, %0d result words over 10 register settings",
                 words_sent, words_seen);
        $display("included zero accel, extreme rates, clamped weights and long stalls");
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== complementary_tilt_filter_top.f =====
sv/ctf_pkg.sv
sv/ctf_cordic_cell.sv
sv/ctf_sqrt.sv
sv/complementary_tilt_filter_top.sv
tb/tb.sv
